### src/rpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpt_pkg
// Shared widths, defaults and configuration register codes for the rigid
// point transform.
// ----------------------------------------------------------------------------
package rpt_pkg;

  localparam int QUAT_W             = 16;
  localparam int COORD_W            = 32;
  localparam int QUAT_FRAC_BITS_DEF = 14;
  localparam int REG_IDX_W          = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ROT_W   = 3'd0,
    REG_ROT_X   = 3'd1,
    REG_ROT_Y   = 3'd2,
    REG_ROT_Z   = 3'd3,
    REG_SHIFT_X = 3'd4,
    REG_SHIFT_Y = 3'd5,
    REG_SHIFT_Z = 3'd6
  } reg_idx_t;

  localparam int W = 0;
  localparam int X = 1;
  localparam int Y = 2;
  localparam int Z = 3;

endpackage

### src/rigid_point_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_point_transform
// Rotates each point by a quaternion (q * (0,p) * conj(q)) and adds a
// translation, with round-half-up after each product and 32-bit saturation.
// Throughput: one point per cycle unless a low out_ready stalls the pipe;
// five register stages.
// Reset clears all stage valid bits and loads the identity quaternion and a
// zero translation.
// ----------------------------------------------------------------------------
module rigid_point_transform #(
  parameter int QUAT_FRAC_BITS = rpt_pkg::QUAT_FRAC_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [rpt_pkg::REG_IDX_W-1:0]          cfg_index,
  input  logic [rpt_pkg::COORD_W-1:0]            cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [rpt_pkg::COORD_W-1:0]     point_x,
  input  logic signed [rpt_pkg::COORD_W-1:0]     point_y,
  input  logic signed [rpt_pkg::COORD_W-1:0]     point_z,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [rpt_pkg::COORD_W-1:0]     out_x,
  output logic signed [rpt_pkg::COORD_W-1:0]     out_y,
  output logic signed [rpt_pkg::COORD_W-1:0]     out_z,
  output logic                                   clipped
);
  import rpt_pkg::*;

  localparam int QW  = QUAT_W;
  localparam int CW  = COORD_W;
  localparam int M1W = QW + CW;
  localparam int S1W = M1W + 2;
  localparam int AW  = S1W - QUAT_FRAC_BITS;
  localparam int M2W = AW + QW;
  localparam int S2W = M2W + 2;
  localparam int RW  = S2W - QUAT_FRAC_BITS;
  localparam int TW  = RW + 1;

  localparam logic signed [QW-1:0]  ROT_ONE = QW'(1) << QUAT_FRAC_BITS;
  localparam logic signed [S1W-1:0] HALF1   = S1W'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [S2W-1:0] HALF2   = S2W'(1) << (QUAT_FRAC_BITS - 1);
  localparam logic signed [CW-1:0]  SAT_MAX = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0]  SAT_MIN = {1'b1, {(CW-1){1'b0}}};

  // configuration
  logic signed [QW-1:0] rot [4];
  logic signed [CW-1:0] shift [3];

  assign cfg_ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      rot[W]   <= ROT_ONE;
      rot[X]   <= '0;
      rot[Y]   <= '0;
      rot[Z]   <= '0;
      shift[0] <= '0;
      shift[1] <= '0;
      shift[2] <= '0;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_ROT_W:   rot[W]   <= cfg_data[QW-1:0];
        REG_ROT_X:   rot[X]   <= cfg_data[QW-1:0];
        REG_ROT_Y:   rot[Y]   <= cfg_data[QW-1:0];
        REG_ROT_Z:   rot[Z]   <= cfg_data[QW-1:0];
        REG_SHIFT_X: shift[0] <= cfg_data;
        REG_SHIFT_Y: shift[1] <= cfg_data;
        REG_SHIFT_Z: shift[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage valids and advance enables
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;

  assign en5      = !out_valid || out_ready;
  assign en4      = !v4 || en5;
  assign en3      = !v3 || en4;
  assign en2      = !v2 || en3;
  assign en1      = !v1 || en2;
  assign in_ready = en1 && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // stage 1: q x p products
  logic signed [CW-1:0]  pin [3];
  logic signed [M1W-1:0] m1 [4][3];

  assign pin[0] = point_x;
  assign pin[1] = point_y;
  assign pin[2] = point_z;

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int j = 0; j < 4; j++) begin
        for (int i = 0; i < 3; i++) begin
          m1[j][i] <= rot[j] * pin[i];
        end
      end
    end
  end

  // stage 2: a = q * (0,p), rounded
  logic signed [S1W-1:0] s1 [4];
  logic signed [S1W-1:0] r1 [4];
  logic signed [AW-1:0]  a [4];

  always_comb begin
    s1[W] = -m1[X][0] - m1[Y][1] - m1[Z][2];
    s1[X] =  m1[W][0] + m1[Y][2] - m1[Z][1];
    s1[Y] =  m1[W][1] - m1[X][2] + m1[Z][0];
    s1[Z] =  m1[W][2] + m1[X][1] - m1[Y][0];
    for (int k = 0; k < 4; k++) begin
      r1[k] = s1[k] + HALF1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int k = 0; k < 4; k++) begin
        a[k] <= r1[k][S1W-1:QUAT_FRAC_BITS];
      end
    end
  end

  // stage 3: a x q products
  logic signed [M2W-1:0] m2 [4][4];

  always_ff @(posedge clk) begin
    if (en3) begin
      for (int j = 0; j < 4; j++) begin
        for (int k = 0; k < 4; k++) begin
          m2[j][k] <= a[j] * rot[k];
        end
      end
    end
  end

  // stage 4: r = a * conj(q), vector part, rounded
  logic signed [S2W-1:0] s2 [3];
  logic signed [S2W-1:0] r2 [3];
  logic signed [RW-1:0]  r [3];

  always_comb begin
    s2[0] = -m2[W][X] + m2[X][W] - m2[Y][Z] + m2[Z][Y];
    s2[1] = -m2[W][Y] + m2[X][Z] + m2[Y][W] - m2[Z][X];
    s2[2] = -m2[W][Z] - m2[X][Y] + m2[Y][X] + m2[Z][W];
    for (int k = 0; k < 3; k++) begin
      r2[k] = s2[k] + HALF2;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      for (int k = 0; k < 3; k++) begin
        r[k] <= r2[k][S2W-1:QUAT_FRAC_BITS];
      end
    end
  end

  // stage 5: translate and saturate
  logic signed [TW-1:0] t [3];
  logic signed [CW-1:0] sat [3];
  logic [2:0]           ovf;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      t[k]   = TW'(r[k]) + TW'(shift[k]);
      ovf[k] = !((&t[k][TW-1:CW-1]) || !(|t[k][TW-1:CW-1]));
      if (!ovf[k]) begin
        sat[k] = t[k][CW-1:0];
      end else if (t[k][TW-1]) begin
        sat[k] = SAT_MIN;
      end else begin
        sat[k] = SAT_MAX;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en5) begin
      out_x   <= sat[0];
      out_y   <= sat[1];
      out_z   <= sat[2];
      clipped <= |ovf;
    end
  end

  // checks
  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("in_ready low while output drains");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (v1 && v2 && v3 && v4 && out_valid && !out_ready) |-> !in_ready)
    else $error("input taken into a full stalled pipe");

  a_clip_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clipped) |-> (out_x == SAT_MAX || out_x == SAT_MIN ||
      out_y == SAT_MAX || out_y == SAT_MIN || out_z == SAT_MAX || out_z == SAT_MIN))
    else $error("clipped set with no coordinate at a bound");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (v4 && !en4) |=> (v4 && $stable(r[0]) && $stable(r[1]) && $stable(r[2])))
    else $error("stalled stage 4 word changed");

endmodule
